// ----- hw/rtl/rme_pkg.sv -----
// Package for the modular exponentiation block: transaction payload types,
// CSR index codes and the status struct of the bit-serial multiplier.
// No dependencies.
`timescale 1ns / 1ps

package rme_pkg;

   // Field widths of the transactions and CSRs
   localparam int FIELD_W = 64;
   localparam int CSR_IDX_W = 2;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PUB_EXP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIV_EXP = 2'd2;

   // Exponent selector codes
   localparam logic OP_PUBLIC = 1'b0;
   localparam logic OP_PRIVATE = 1'b1;

   // Request transaction
   typedef struct packed {
      logic               op;
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] expected;
   } rme_req_type;

   // Response transaction
   typedef struct packed {
      logic [FIELD_W-1:0] result;
      logic               matches_res;
   } rme_rsp_type;

   // Multiplier status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } rme_mul_stat_type;

endpackage

// ----- hw/rtl/rme_modmul.sv -----
// Bit-serial modular multiplier: product = x * y mod modulus, one bit of y
// per cycle, MSB first (double and add). Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_modmul
   import rme_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] modulus,
   input  logic [WIDTH-1:0] mul_x,
   input  logic [WIDTH-1:0] mul_y,
   output logic [WIDTH-1:0] product,
   output rme_mul_stat_type stat
);

   localparam int CW = $clog2(WIDTH);
   localparam int EW = WIDTH + 3;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] y_ff, y_in;

   logic [EW-1:0] dbl, m_ext, x_ext;
   logic [EW-1:0] t_dbl_m, t_add, t_add_m, t_add_2m;
   logic [WIDTH-1:0] acc_step;

   // Candidate sums, all in parallel; operands x, acc are below modulus
   always_comb begin
      dbl      = {2'b00, acc_ff, 1'b0};
      m_ext    = {3'b000, modulus};
      x_ext    = {3'b000, mul_x};
      t_dbl_m  = dbl - m_ext;
      t_add    = dbl + x_ext;
      t_add_m  = dbl + x_ext - m_ext;
      t_add_2m = dbl + x_ext - {m_ext[EW-2:0], 1'b0};
   end

   // Pick the smallest non-negative candidate
   always_comb begin
      if (y_ff[WIDTH-1]) begin
         priority if (!t_add_2m[EW-1]) acc_step = t_add_2m[WIDTH-1:0];
         else if (!t_add_m[EW-1]) acc_step = t_add_m[WIDTH-1:0];
         else acc_step = t_add[WIDTH-1:0];
      end else begin
         if (!t_dbl_m[EW-1]) acc_step = t_dbl_m[WIDTH-1:0];
         else acc_step = dbl[WIDTH-1:0];
      end
   end

   // Sequencing of one multiplication
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      y_in    = y_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(WIDTH - 1);
         acc_in = '0;
         y_in   = mul_y;
      end else if (run_ff) begin
         acc_in = acc_step;
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      y_ff   <= y_in;
   end

   assign product   = acc_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

endmodule

// ----- hw/rtl/rsa_modular_exponentiation_top.sv -----
// Top level of the modular exponentiation block: CSRs, square-and-multiply
// sequencer and response register. Depends on rme_pkg and rme_modmul.
// One transaction at a time; busy is high while one is in progress and drops
// in the cycle the response is shown, so the next one is taken at that edge.
// Synchronous active-high reset: modulus 1, exponents 0, sequencer idle.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_top
   import rme_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rme_req_type          req_data,
   output logic                 rsp_valid,
   output rme_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(WIDTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RED_B,
      S_RED_W,
      S_SQR,
      S_MUL
   } state_type;

   // CSRs
   logic [WIDTH-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= WIDTH'(1);
         pub_exp_ff  <= '0;
         priv_exp_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_ff  <= csr_wdata[WIDTH-1:0];
            CSR_PUB_EXP:  pub_exp_ff  <= csr_wdata[WIDTH-1:0];
            CSR_PRIV_EXP: priv_exp_ff <= csr_wdata[WIDTH-1:0];
            default: ;
         endcase
      end
   end

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [CW-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [WIDTH-1:0] bred_ff, bred_in;
   logic [WIDTH-1:0] wred_ff, wred_in;
   logic             mul_start_ff, mul_start_in;
   logic [WIDTH-1:0] mul_x_ff, mul_x_in;
   logic [WIDTH-1:0] mul_y_ff, mul_y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rme_rsp_type      rsp_data_ff, rsp_data_in;

   logic [WIDTH-1:0] product;
   rme_mul_stat_type mul_stat;
   logic [WIDTH-1:0] one_res;
   logic             last_bit;

   // 1 mod modulus
   assign one_res  = (modulus_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
   assign last_bit = (bit_cnt_ff == '0);

   rme_modmul #(
      .WIDTH(WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .modulus (modulus_ff),
      .mul_x   (mul_x_ff),
      .mul_y   (mul_y_ff),
      .product (product),
      .stat    (mul_stat)
   );

   // Square-and-multiply sequencer
   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      bred_in      = bred_ff;
      wred_in      = wred_ff;
      mul_start_in = 1'b0;
      mul_x_in     = mul_x_ff;
      mul_y_in     = mul_y_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               exp_in = (req_data.op == OP_PRIVATE) ? priv_exp_ff : pub_exp_ff;
               if (modulus_ff == '0) begin
                  // no valid residue
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.result      = '0;
                  rsp_data_in.matches_res = 1'b0;
               end else begin
                  // base mod n as 1 * base
                  mul_start_in = 1'b1;
                  mul_x_in     = one_res;
                  mul_y_in     = req_data.base[WIDTH-1:0];
                  wred_in      = req_data.expected[WIDTH-1:0];
                  state_in     = S_RED_B;
               end
            end
         end
         S_RED_B: begin
            if (mul_stat.done) begin
               bred_in      = product;
               mul_start_in = 1'b1;
               mul_x_in     = one_res;
               mul_y_in     = wred_ff;
               state_in     = S_RED_W;
            end
         end
         S_RED_W: begin
            if (mul_stat.done) begin
               wred_in = product;
               if (exp_ff == '0) begin
                  // zero exponent gives 1, unreduced
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.result      = FIELD_W'(1);
                  rsp_data_in.matches_res = (product == WIDTH'(1));
                  state_in                = S_IDLE;
               end else begin
                  mul_start_in = 1'b1;
                  mul_x_in     = one_res;
                  mul_y_in     = one_res;
                  bit_cnt_in   = CW'(WIDTH - 1);
                  state_in     = S_SQR;
               end
            end
         end
         S_SQR: begin
            if (mul_stat.done) begin
               if (exp_ff[WIDTH-1]) begin
                  mul_start_in = 1'b1;
                  mul_x_in     = product;
                  mul_y_in     = bred_ff;
                  state_in     = S_MUL;
               end else begin
                  exp_in = {exp_ff[WIDTH-2:0], 1'b0};
                  if (last_bit) begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.result      = FIELD_W'(product);
                     rsp_data_in.matches_res = (product == wred_ff);
                     state_in                = S_IDLE;
                  end else begin
                     bit_cnt_in   = bit_cnt_ff - 1'b1;
                     mul_start_in = 1'b1;
                     mul_x_in     = product;
                     mul_y_in     = product;
                  end
               end
            end
         end
         S_MUL: begin
            if (mul_stat.done) begin
               exp_in = {exp_ff[WIDTH-2:0], 1'b0};
               if (last_bit) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.result      = FIELD_W'(product);
                  rsp_data_in.matches_res = (product == wred_ff);
                  state_in                = S_IDLE;
               end else begin
                  bit_cnt_in   = bit_cnt_ff - 1'b1;
                  mul_start_in = 1'b1;
                  mul_x_in     = product;
                  mul_y_in     = product;
                  state_in     = S_SQR;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff      <= exp_in;
      bit_cnt_ff  <= bit_cnt_in;
      bred_ff     <= bred_in;
      wred_ff     <= wred_in;
      mul_x_ff    <= mul_x_in;
      mul_y_ff    <= mul_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Multiplier is only started when it is free and a step is pending
   a_mul_start_free: assert property (@(posedge clock) disable iff (reset)
      mul_start_ff |-> (!mul_stat.busy && state_ff != S_IDLE))
      else $error("multiplier started while busy or with sequencer idle");

   // Multiplier completion only while the sequencer waits for it
   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == S_RED_B || state_ff == S_RED_W ||
                         state_ff == S_SQR || state_ff == S_MUL))
      else $error("multiplier done with no pending step");

   // An accepted transaction either starts work or responds at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction dropped");

   // A response is shown only once the sequencer is back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while transaction still in progress");

endmodule

// ----- tb/testbench.sv -----
// Testbench for rsa_modular_exponentiation_top: directed and random
// exponentiation transactions checked against a scoreboard class.
// Depends on rme_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import rme_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   // Longer than one slow transaction: catches any stray response at the end
   localparam int DRAIN_CYCLES = 9000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // Toy RSA key: n = 61 * 53, e = 17, d = 2753
   localparam logic [FIELD_W-1:0] TOY_N = 64'd3233;
   localparam logic [FIELD_W-1:0] TOY_E = 64'd17;
   localparam logic [FIELD_W-1:0] TOY_D = 64'd2753;
   localparam logic [FIELD_W-1:0] TOY_MSG = 64'd65;
   localparam logic [FIELD_W-1:0] TOY_CIPHER = 64'd2790;
   localparam logic [FIELD_W-1:0] ALL_ONES = '1;

   // Scoreboard: key copy, exponentiation predictor, queue of awaited results
   class rme_scoreboard;
      logic [FIELD_W-1:0] modulus;
      logic [FIELD_W-1:0] pub_exp;
      logic [FIELD_W-1:0] priv_exp;
      rme_rsp_type awaited_results[$];
      int mismatches;

      function new();
         modulus = 64'd1;
         pub_exp = '0;
         priv_exp = '0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
         case (idx)
            CSR_MODULUS: modulus = value;
            CSR_PUB_EXP: pub_exp = value;
            CSR_PRIV_EXP: priv_exp = value;
            default: ;
         endcase
      endfunction

      // (a * b) mod m with a full-width product
      function logic [FIELD_W-1:0] mul_mod(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                           logic [FIELD_W-1:0] m);
         logic [2*FIELD_W-1:0] wide;
         wide = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
         wide = wide % {{FIELD_W{1'b0}}, m};
         return wide[FIELD_W-1:0];
      endfunction

      // Left-to-right square and multiply; zero exponent gives 1 even for m = 1
      function logic [FIELD_W-1:0] power_mod(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
                                             logic [FIELD_W-1:0] m);
         logic [FIELD_W-1:0] acc;
         logic [FIELD_W-1:0] reduced;
         if (e == '0)
            return 64'd1;
         reduced = b % m;
         acc = (m == 64'd1) ? '0 : 64'd1;
         for (int i = FIELD_W - 1; i >= 0; i--) begin
            acc = mul_mod(acc, acc, m);
            if (e[i])
               acc = mul_mod(acc, reduced, m);
         end
         return acc;
      endfunction

      function rme_rsp_type expected_response(rme_req_type req);
         rme_rsp_type rsp;
         logic [FIELD_W-1:0] e;
         e = (req.op == OP_PRIVATE) ? priv_exp : pub_exp;
         if (modulus == '0) begin
            // No valid residue for a zero modulus
            rsp.result = '0;
            rsp.matches_res = 1'b0;
            return rsp;
         end
         rsp.result = power_mod(req.base, e, modulus);
         rsp.matches_res = (rsp.result == req.expected % modulus);
         return rsp;
      endfunction

      function void note_request(rme_req_type req);
         awaited_results.push_back(expected_response(req));
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction

      task report(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      task check_response(rme_rsp_type got);
         rme_rsp_type want;
         if (awaited_results.size() == 0) begin
            report($sformatf("response with nothing outstanding: result=%h", got.result));
            return;
         end
         want = awaited_results.pop_front();
         if (got.result !== want.result)
            report($sformatf("result %h, predicted %h", got.result, want.result));
         if (got.matches_res !== want.matches_res)
            report($sformatf("matches_res %b, predicted %b (result %h)",
                             got.matches_res, want.matches_res, want.result));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   rme_req_type          req_data;
   logic                 rsp_valid;
   rme_rsp_type          rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;

   rme_scoreboard sb;
   int stall_cycles;
   bit sender_idles;

   rsa_modular_exponentiation_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Monitor: CSR writes, responses, accepted requests, then the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.write_register(csr_index, csr_wdata);
         if (rsp_valid)
            sb.check_response(rsp_data);
         if (start && !busy)
            sb.note_request(req_data);
         if ((start && !busy) || rsp_valid || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic [FIELD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Expected value: often the true result, sometimes an unreduced alias of it, else a random word
   function automatic logic [FIELD_W-1:0] pick_expected(logic op, logic [FIELD_W-1:0] base);
      rme_req_type probe;
      rme_rsp_type rsp;
      logic [FIELD_W:0] lifted;
      probe.op = op;
      probe.base = base;
      probe.expected = '0;
      rsp = sb.expected_response(probe);
      lifted = {1'b0, rsp.result} + {1'b0, sb.modulus};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return rsp.result;
         4: return lifted[FIELD_W] ? rsp.result : lifted[FIELD_W-1:0];
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_base();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2: return sb.modulus;
         3: return sb.modulus - 64'd1;
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_modulus();
      case ($urandom_range(0, 11))
         0: return 64'd1;
         1: return ALL_ONES;
         2: return 64'($urandom_range(2, 65535));
         3: return '0;
         // top bit set, odd
         4: return rand_word() | 64'h8000_0000_0000_0001;
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_exponent();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 64'd1;
         2: return ALL_ONES;
         3: return 64'($urandom_range(2, 255));
         default: return rand_word();
      endcase
   endfunction

   // One request transaction; the sender may idle in any cycle before it is
   // taken. Returns at the falling edge after acceptance.
   task automatic issue(input logic op, input logic [FIELD_W-1:0] base,
                        input logic [FIELD_W-1:0] expected);
      rme_req_type req;
      bit accepted;
      req.op = op;
      req.base = base;
      req.expected = expected;
      accepted = 1'b0;
      while (!accepted) begin
         if (sender_idles && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            req_data <= {1'($urandom), rand_word(), rand_word()};
         end else begin
            start <= 1'b1;
            req_data <= req;
         end
         @(posedge clock);
         accepted = start && !busy;
         @(negedge clock);
      end
   endtask

   task automatic issue_random();
      logic op;
      logic [FIELD_W-1:0] base;
      op = 1'($urandom_range(0, 1));
      base = pick_base();
      issue(op, base, pick_expected(op, base));
   endtask

   // Stop requesting and wait until every result is in and the block is idle
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.outstanding() != 0 || busy)
         @(negedge clock);
   endtask

   // Load a key while idle; optionally also poke the unmapped CSR index
   task automatic load_key(input logic [FIELD_W-1:0] modulus, input logic [FIELD_W-1:0] pub,
                           input logic [FIELD_W-1:0] priv, input bit poke_unmapped);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_MODULUS;
      csr_wdata <= modulus;
      @(negedge clock);
      csr_index <= CSR_PUB_EXP;
      csr_wdata <= pub;
      @(negedge clock);
      csr_index <= CSR_PRIV_EXP;
      csr_wdata <= priv;
      @(negedge clock);
      if (poke_unmapped) begin
         csr_index <= CSR_UNMAPPED;
         csr_wdata <= rand_word();
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      sb = new();
      stall_cycles = 0;
      sender_idles = 1'b1;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_MODULUS;
      csr_wdata = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Reset key: modulus 1, zero exponents, so every result is 1
      issue(OP_PUBLIC, '0, '0);
      issue(OP_PRIVATE, ALL_ONES, ALL_ONES);

      // Toy key round trip, base not below modulus, zero base
      load_key(TOY_N, TOY_E, TOY_D, 1'b0);
      issue(OP_PUBLIC, TOY_MSG, TOY_CIPHER);
      issue(OP_PRIVATE, TOY_CIPHER, TOY_MSG);
      issue(OP_PUBLIC, TOY_N + TOY_MSG, TOY_CIPHER);
      issue(OP_PRIVATE, ALL_ONES, ALL_ONES);
      issue(OP_PUBLIC, '0, TOY_N);
      issue(OP_PRIVATE, 64'd1, TOY_N + 64'd1);

      // Largest modulus and exponent
      load_key(ALL_ONES, ALL_ONES, 64'd1, 1'b0);
      issue(OP_PUBLIC, ALL_ONES, '0);
      issue(OP_PRIVATE, ALL_ONES - 64'd1, ALL_ONES - 64'd1);
      issue(OP_PUBLIC, 64'd2, rand_word());
      issue(OP_PRIVATE, 64'h8000_0000_0000_0000, ALL_ONES);

      // Zero modulus; the unmapped index must not disturb the key
      load_key('0, 64'd5, '0, 1'b1);
      issue(OP_PUBLIC, 64'd7, '0);
      issue(OP_PRIVATE, ALL_ONES, ALL_ONES);

      // Modulus 1: nonzero exponent gives 0, zero exponent gives 1
      load_key(64'd1, 64'd1, '0, 1'b0);
      issue(OP_PUBLIC, 64'd5, '0);
      issue(OP_PRIVATE, 64'd5, '0);

      // Large odd modulus with the usual public exponent
      load_key(64'hC96F_2A1D_0B37_E5A9, 64'd65537, rand_word(), 1'b0);
      repeat (3) issue_random();

      // Random keys; the middle phase runs without sender idling
      for (int phase = 0; phase < 5; phase++) begin
         load_key(pick_modulus(), pick_exponent(), pick_exponent(), phase == 3);
         sender_idles = (phase != 2);
         repeat (20) issue_random();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("Verification passed");
      else begin
         if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
         $display("Verification failed");
      end
      $finish;
   end

endmodule
